// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFGS_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FFGS_ASSERT(label, prop, msg)
`define FFGS_ASSERT_NORST(label, prop, msg)
`endif
`endif

// ===== rtl/ffgs_pkg.sv =====
// Package with shared constants, codes, command/status structs and the random function
`timescale 1ns / 1ps
package ffgs_pkg;

  localparam int FIELD_WIDTH_DEF  = 64;
  localparam int FIELD_HEIGHT_DEF = 64;

  localparam int ROW_W      = 9;   // row index width covering the largest field
  localparam int SEED_W     = 32;
  localparam int DENS_W     = 10;
  localparam int SEEDCNT_W  = 6;
  localparam int OP_W       = 2;
  localparam int CELL_ROW_W = 7;
  localparam int CELL_COL_W = 6;
  localparam int LEVEL_W    = 8;

  localparam int DENS_START  = 4;
  localparam int DENS_STEP   = 10;
  localparam int DENS_LIMIT  = 511;
  localparam int SEED_BIAS   = 4;
  localparam int BURN_LEVEL  = 126;
  localparam int LEVEL_MAX   = 255;
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RD_UP     = 3'd0,
    RD_LO     = 3'd1,
    RD_SEED   = 3'd2,
    RD_MIRROR = 3'd3,
    RD_CELL   = 3'd4
  } rsel_e;

  typedef enum logic [2:0] {
    WR_ZERO   = 3'd0,
    WR_SEED   = 3'd1,
    WR_MIRROR = 3'd2,
    WR_AVG    = 3'd3,
    WR_MEAN   = 3'd4
  } wsel_e;

  typedef struct packed {
    logic             ram_we;
    wsel_e            wsel;
    rsel_e            rsel;
    logic [ROW_W-1:0] row;
    logic             capture;
    logic             start;
    logic             prep;
    logic             off_sub;
    logic             draw;
    logic             hold_r1;
    logic             hold_up;
    logic             calc;
    logic             seed_adv;
    logic             take_cell;
    logic             dens_upd;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic [SEEDCNT_W-1:0] seed_num;
    logic                 off_wrap;
  } stat_t;

  function automatic logic [SEED_W-1:0] xorshift32(logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// ===== rtl/fire_field_generation_step.sv =====
// Top level of the fire heat-field generator: controller, datapath and checks
// Step: prepares, wraps the offset, seeds density/8 cells, averages FIELD_HEIGHT/2+1 row pairs,
//   then updates density, all by row-serial RAM access (a row at a time).
// Start: clears FIELD_HEIGHT+5 rows, one row per cycle. Read: one row read. No-op: no RAM access.
// One item at a time; the result register lets the next item enter while a result waits.
// Reset: clears density to 4, offset to 0, seed and random state to 1, then sweeps
//   FIELD_HEIGHT+5 rows to zero with the input stalled; configuration writes still land.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fire_field_generation_step #(
  parameter int FIELD_WIDTH  = ffgs_pkg::FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = ffgs_pkg::FIELD_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ffgs_pkg::OP_W-1:0]          operation_i,
  input  logic [ffgs_pkg::CELL_ROW_W-1:0]    cell_row_i,
  input  logic [ffgs_pkg::CELL_COL_W-1:0]    cell_col_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ffgs_pkg::DENS_W-1:0] heat_density_o,
  output logic                               burn_done_o,
  output logic [ffgs_pkg::LEVEL_W-1:0]       cell_level_o,
  // random seed register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffgs_pkg::SEED_W-1:0]        cfg_data_i
);

  localparam int DENS_CAP = (7 * FIELD_WIDTH > ffgs_pkg::DENS_LIMIT) ?
                            ffgs_pkg::DENS_LIMIT : 7 * FIELD_WIDTH;
  localparam logic signed [ffgs_pkg::DENS_W-1:0] DENS_CAP_S = ffgs_pkg::DENS_W'(DENS_CAP);

  ffgs_pkg::cmd_t  cmd;
  ffgs_pkg::stat_t stat;

  // The seed register takes a write beat in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer: walks clear, seed, average, density and read phases and owns the input and result handshakes.
  ffgs_ctrl #(
    .FIELD_HEIGHT(FIELD_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: row-wide field RAM, one lane per column, random source and result beat.
  ffgs_dp #(
    .FIELD_WIDTH (FIELD_WIDTH),
    .FIELD_HEIGHT(FIELD_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .heat_density_o(heat_density_o),
    .burn_done_o   (burn_done_o),
    .cell_level_o  (cell_level_o)
  );

  // An accepted item always holds off the next one.
  `FFGS_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "no stall")
  // A burnt-out field shows exactly density -1.
  `FFGS_ASSERT(a_done_density, out_valid_o |-> (burn_done_o == (&heat_density_o)), "done")
  // A live density never passes its cap.
  `FFGS_ASSERT(a_density_cap, (out_valid_o && !burn_done_o) |-> (heat_density_o <= DENS_CAP_S), "cap")

endmodule

// ===== rtl/ffgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ffgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ffgs_ctrl.sv =====
// Sequencer for clear, seed, average, density and read operations
`timescale 1ns / 1ps
module ffgs_ctrl #(
  parameter int FIELD_HEIGHT = ffgs_pkg::FIELD_HEIGHT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ffgs_pkg::OP_W-1:0] operation_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  ffgs_pkg::stat_t           stat_i,
  output ffgs_pkg::cmd_t            cmd_o
);

  localparam int ROWS = FIELD_HEIGHT + 5;
  localparam int AW   = $clog2(ROWS);

  typedef enum logic [14:0] {
    S_CLEAR     = 15'h0001,
    S_IDLE      = 15'h0002,
    S_READ      = 15'h0004,
    S_READ_WAIT = 15'h0008,
    S_PREP      = 15'h0010,
    S_NORM      = 15'h0020,
    S_SEED_RD   = 15'h0040,
    S_SEED_WR   = 15'h0080,
    S_SEED_MIR  = 15'h0100,
    S_AVG_UP    = 15'h0200,
    S_AVG_LO    = 15'h0400,
    S_AVG_CALC  = 15'h0800,
    S_AVG_WR2   = 15'h1000,
    S_DENS      = 15'h2000,
    S_FINISH    = 15'h4000
  } state_e;

  state_e                         state_q, state_d;
  logic [AW-1:0]                  row_q, row_d;
  logic [ffgs_pkg::SEEDCNT_W-1:0] seed_q, seed_d;
  logic                           clr_start_q, clr_start_d;
  logic                           out_valid_q, out_valid_d;
  ffgs_pkg::cmd_t                 cmd;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    seed_d      = seed_q;
    clr_start_d = clr_start_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    cmd.wsel    = ffgs_pkg::WR_ZERO;
    cmd.rsel    = ffgs_pkg::RD_UP;
    cmd.row     = ffgs_pkg::ROW_W'(row_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = ffgs_pkg::WR_ZERO;
        row_d      = row_q + AW'(1);
        if (row_q == AW'(ROWS - 1)) begin
          row_d       = '0;
          clr_start_d = 1'b0;
          state_d     = clr_start_q ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          unique case (ffgs_pkg::op_e'(operation_i))
            ffgs_pkg::OP_START: begin
              cmd.start   = 1'b1;
              clr_start_d = 1'b1;
              row_d       = '0;
              state_d     = S_CLEAR;
            end
            ffgs_pkg::OP_STEP: state_d = S_PREP;
            ffgs_pkg::OP_READ: state_d = S_READ;
            ffgs_pkg::OP_NOP:  state_d = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        cmd.rsel = ffgs_pkg::RD_CELL;
        state_d  = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        cmd.take_cell = 1'b1;
        state_d       = S_FINISH;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        seed_d   = '0;
        row_d    = '0;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (stat_i.off_wrap) begin
          cmd.off_sub = 1'b1;
        end else if (stat_i.seed_num == '0) begin
          state_d = S_AVG_UP;
        end else begin
          state_d = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        cmd.rsel    = ffgs_pkg::RD_SEED;
        cmd.draw    = 1'b1;
        cmd.hold_r1 = 1'b1;
        state_d     = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = ffgs_pkg::WR_SEED;
        cmd.draw   = 1'b1;
        cmd.rsel   = ffgs_pkg::RD_MIRROR;
        state_d    = S_SEED_MIR;
      end
      S_SEED_MIR: begin
        cmd.ram_we   = 1'b1;
        cmd.wsel     = ffgs_pkg::WR_MIRROR;
        cmd.seed_adv = 1'b1;
        seed_d       = seed_q + ffgs_pkg::SEEDCNT_W'(1);
        state_d      = (seed_d == stat_i.seed_num) ? S_AVG_UP : S_SEED_RD;
      end
      S_AVG_UP: begin
        cmd.rsel = ffgs_pkg::RD_UP;
        state_d  = S_AVG_LO;
      end
      S_AVG_LO: begin
        cmd.rsel    = ffgs_pkg::RD_LO;
        cmd.hold_up = 1'b1;
        state_d     = S_AVG_CALC;
      end
      S_AVG_CALC: begin
        cmd.calc   = 1'b1;
        cmd.ram_we = 1'b1;
        cmd.wsel   = ffgs_pkg::WR_AVG;
        state_d    = S_AVG_WR2;
      end
      S_AVG_WR2: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = ffgs_pkg::WR_MEAN;
        row_d      = row_q + AW'(2);
        state_d    = S_AVG_UP;
        if (int'(row_q) + 2 > FIELD_HEIGHT) begin
          row_d   = '0;
          state_d = S_DENS;
        end
      end
      S_DENS: begin
        cmd.dens_upd = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      seed_q      <= '0;
      clr_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      seed_q      <= seed_d;
      clr_start_q <= clr_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== rtl/ffgs_dp.sv =====
// Datapath: field RAM, row lanes, seeding, random source, density and result registers
`timescale 1ns / 1ps
module ffgs_dp #(
  parameter int FIELD_WIDTH  = ffgs_pkg::FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = ffgs_pkg::FIELD_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ffgs_pkg::cmd_t                    cmd_i,
  output ffgs_pkg::stat_t                   stat_o,
  input  logic [ffgs_pkg::CELL_ROW_W-1:0]   cell_row_i,
  input  logic [ffgs_pkg::CELL_COL_W-1:0]   cell_col_i,
  input  logic                              cfg_valid_i,
  input  logic [ffgs_pkg::SEED_W-1:0]       cfg_data_i,
  output logic signed [ffgs_pkg::DENS_W-1:0] heat_density_o,
  output logic                              burn_done_o,
  output logic [ffgs_pkg::LEVEL_W-1:0]      cell_level_o
);

  localparam int ROWS     = FIELD_HEIGHT + 5;
  localparam int AW       = $clog2(ROWS);
  localparam int CW       = $clog2(FIELD_WIDTH);
  localparam int OFF_W    = $clog2(4 * FIELD_WIDTH);
  localparam int HALF     = FIELD_WIDTH / 2;
  localparam int DENS_CAP = (7 * FIELD_WIDTH > ffgs_pkg::DENS_LIMIT) ?
                            ffgs_pkg::DENS_LIMIT : 7 * FIELD_WIDTH;
  localparam logic signed [ffgs_pkg::DENS_W:0] DENS_CAP_S = (ffgs_pkg::DENS_W + 1)'(DENS_CAP);

  typedef logic [FIELD_WIDTH-1:0][7:0] row_t;

  logic [ffgs_pkg::SEED_W-1:0]        seed_q, rand_q, rand_nx;
  logic signed [ffgs_pkg::DENS_W-1:0] dens_q, dens_out_q;
  logic [OFF_W-1:0]                   off_q;
  logic [CW-1:0]                      col_q, mir_col;
  logic [8:0]                         d_q, d_nx;
  logic [18:0]                        d_prod;
  logic [7:0]                         r1_q, v_q, rnd, v, old_cell, cell_byte;
  logic [7:0]                         level_q, level_out_q;
  logic                               done_q, ok_c, ok_m, vis_c, vis_m, cell_in_range;
  logic [ffgs_pkg::CELL_ROW_W-1:0]    row_cap_q;
  logic [ffgs_pkg::CELL_COL_W-1:0]    col_cap_q;
  logic [9:0]                         seed_sum;
  logic [CW:0]                        mir_sum;
  logic signed [ffgs_pkg::DENS_W:0]   dens_nx;
  row_t                               rd, up_q, mean_q, seed_row, mir_row, calc_row, mean_row;
  row_t                               wdata;
  logic [AW-1:0]                      row_a, raddr, waddr;
  logic [FIELD_WIDTH-1:0][9:0]        sum4;
  logic [FIELD_WIDTH-1:0][8:0]        sum2;

  ffgs_ram #(
    .WIDTH(FIELD_WIDTH * 8),
    .DEPTH(ROWS)
  ) u_field (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  assign row_a   = cmd_i.row[AW-1:0];
  assign rand_nx = ffgs_pkg::xorshift32(rand_q);
  assign rnd     = rand_nx[7:0];
  assign cell_in_range = (int'(row_cap_q) < ROWS) && (int'(col_cap_q) < FIELD_WIDTH);

  always_comb begin
    unique case (cmd_i.rsel)
      ffgs_pkg::RD_UP:     raddr = row_a + AW'(2);
      ffgs_pkg::RD_LO:     raddr = row_a + AW'(4);
      ffgs_pkg::RD_SEED:   raddr = AW'(FIELD_HEIGHT);
      ffgs_pkg::RD_MIRROR: raddr = AW'(FIELD_HEIGHT + 2);
      ffgs_pkg::RD_CELL:   raddr = cell_in_range ? AW'(row_cap_q) : '0;
      default:             raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wsel)
      ffgs_pkg::WR_ZERO: begin
        waddr = row_a;
        wdata = '0;
      end
      ffgs_pkg::WR_SEED: begin
        waddr = AW'(FIELD_HEIGHT);
        wdata = seed_row;
      end
      ffgs_pkg::WR_MIRROR: begin
        waddr = AW'(FIELD_HEIGHT + 2);
        wdata = mir_row;
      end
      ffgs_pkg::WR_AVG: begin
        waddr = row_a;
        wdata = calc_row;
      end
      ffgs_pkg::WR_MEAN: begin
        waddr = row_a + AW'(1);
        wdata = mean_q;
      end
      default: begin
        waddr = row_a;
        wdata = '0;
      end
    endcase
  end

  // Seed value and the mirror column
  always_comb begin
    old_cell = rd[col_q];
    seed_sum = 10'(old_cell) + 10'(ffgs_pkg::SEED_BIAS) + 10'(r1_q[3:0]) + 10'(r1_q[7:3])
             + 10'(rnd[4:0]);
    v = (seed_sum > 10'(ffgs_pkg::LEVEL_MAX)) ? 8'(ffgs_pkg::LEVEL_MAX) : seed_sum[7:0];
    mir_sum = (CW + 1)'(col_q) + (CW + 1)'(HALF);
    if (mir_sum >= (CW + 1)'(FIELD_WIDTH)) begin
      mir_sum = mir_sum - (CW + 1)'(FIELD_WIDTH);
    end
    mir_col = mir_sum[CW-1:0];
    for (int i = 0; i < FIELD_WIDTH; i++) begin
      seed_row[i] = (CW'(i) == col_q) ? v : rd[i];
      mir_row[i]  = (CW'(i) == mir_col) ? v_q : rd[i];
    end
  end

  // Averaging lanes, one per column, with wrapped neighbors
  always_comb begin
    ok_c = 1'b1;
    ok_m = 1'b1;
    for (int i = 0; i < FIELD_WIDTH; i++) begin
      sum4[i] = 10'(up_q[i]) + 10'(up_q[(i + FIELD_WIDTH - 1) % FIELD_WIDTH])
              + 10'(up_q[(i + 1) % FIELD_WIDTH]) + 10'(rd[i]);
      calc_row[i] = sum4[i][9:2];
      if (calc_row[i] > 8'd1) begin
        calc_row[i] = calc_row[i] - 8'd1;
      end
      sum2[i]     = 9'(calc_row[i]) + 9'(rd[i]);
      mean_row[i] = sum2[i][8:1];
      ok_c = ok_c & (calc_row[i] >= 8'(ffgs_pkg::BURN_LEVEL));
      ok_m = ok_m & (mean_row[i] >= 8'(ffgs_pkg::BURN_LEVEL));
    end
    vis_c = int'(row_a) < FIELD_HEIGHT;
    vis_m = int'(row_a) + 1 < FIELD_HEIGHT;
  end

  assign d_nx      = dens_q[ffgs_pkg::DENS_W-1] ? 9'd0 : dens_q[8:0];
  assign d_prod    = 19'(d_nx) * 19'(ffgs_pkg::DIV3_MUL);
  assign cell_byte = rd[CW'(col_cap_q)];
  assign dens_nx   = (ffgs_pkg::DENS_W + 1)'(dens_q) + (ffgs_pkg::DENS_W + 1)'(ffgs_pkg::DENS_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= ffgs_pkg::SEED_W'(1);
      rand_q <= ffgs_pkg::SEED_W'(1);
      dens_q <= ffgs_pkg::DENS_W'(ffgs_pkg::DENS_START);
      off_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        rand_q <= seed_q;
        dens_q <= ffgs_pkg::DENS_W'(ffgs_pkg::DENS_START);
      end
      if (cmd_i.draw) begin
        rand_q <= rand_nx;
      end
      if (cmd_i.prep) begin
        off_q  <= off_q + OFF_W'(d_prod[18:ffgs_pkg::DIV3_SHIFT]);
        done_q <= 1'b1;
      end
      if (cmd_i.off_sub) begin
        off_q <= off_q - OFF_W'(FIELD_WIDTH);
      end
      if (cmd_i.calc) begin
        done_q <= done_q & (!vis_c | ok_c) & (!vis_m | ok_m);
      end
      if (cmd_i.dens_upd) begin
        if (done_q) begin
          dens_q <= '1;
        end else if (dens_nx > DENS_CAP_S) begin
          dens_q <= ffgs_pkg::DENS_W'(DENS_CAP);
        end else begin
          dens_q <= dens_nx[ffgs_pkg::DENS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_cap_q <= cell_row_i;
      col_cap_q <= cell_col_i;
      level_q   <= '0;
    end
    if (cmd_i.take_cell) begin
      level_q <= cell_in_range ? cell_byte : 8'd0;
    end
    if (cmd_i.prep) begin
      d_q   <= d_nx;
      col_q <= CW'(off_q);
    end
    if (cmd_i.hold_r1) begin
      r1_q <= rnd;
    end
    if (cmd_i.ram_we && cmd_i.wsel == ffgs_pkg::WR_SEED) begin
      v_q <= v;
    end
    if (cmd_i.seed_adv) begin
      col_q <= (col_q == CW'(FIELD_WIDTH - 1)) ? '0 : col_q + CW'(1);
    end
    if (cmd_i.hold_up) begin
      up_q <= rd;
    end
    if (cmd_i.calc) begin
      mean_q <= mean_row;
    end
    if (cmd_i.load_out) begin
      dens_out_q  <= dens_q;
      level_out_q <= level_q;
    end
  end

  assign stat_o.seed_num = d_q[8:3];
  assign stat_o.off_wrap = (off_q >= OFF_W'(FIELD_WIDTH));

  assign heat_density_o = dens_out_q;
  assign burn_done_o    = dens_out_q[ffgs_pkg::DENS_W-1];
  assign cell_level_o   = level_out_q;

endmodule

// ===== sim/fire_field_generation_step_tb.sv =====
// Self-checking testbench for the fire heat-field generator top level
`timescale 1ns / 1ps
module fire_field_generation_step_tb;

  localparam int FW         = 64;
  localparam int FH         = 64;
  localparam int FROWS      = FH + 5;
  localparam int CELLS      = FW * FROWS;
  localparam int DENS_CAP   = 448;        // FIELD_WIDTH*7, below the 511 ceiling
  localparam int SETTLE     = 250;        // idle cycles before a seed write and at the end
  localparam int IDLE_LIMIT = 6000;       // cycles with no beat on either channel
  localparam int LONG_HOLD  = 400;        // receiver hold-off that fills the block

  typedef struct packed {
    logic signed [ffgs_pkg::DENS_W-1:0] dens;
    logic                               done;
    logic [ffgs_pkg::LEVEL_W-1:0]       level;
  } heat_res_t;

  typedef struct packed {
    ffgs_pkg::op_e                   op;
    logic [ffgs_pkg::CELL_ROW_W-1:0] row;
    logic [ffgs_pkg::CELL_COL_W-1:0] col;
    logic                            typed;   // expectation typed in below
    heat_res_t                       res;
  } heat_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ffgs_pkg::OP_W-1:0] operation_i = '0;
  logic [ffgs_pkg::CELL_ROW_W-1:0] cell_row_i = '0;
  logic [ffgs_pkg::CELL_COL_W-1:0] cell_col_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [ffgs_pkg::DENS_W-1:0] heat_density_o;
  logic burn_done_o;
  logic [ffgs_pkg::LEVEL_W-1:0] cell_level_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ffgs_pkg::SEED_W-1:0] cfg_data_i = '0;

  fire_field_generation_step u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .operation_i, .cell_row_i, .cell_col_i,
    .out_valid_o, .out_stall_i, .heat_density_o, .burn_done_o, .cell_level_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the block's state
  logic [7:0]  heat_mem [CELLS];
  int          dens_lvl;
  int          seed_col;
  logic [31:0] rnd_state;
  logic [31:0] seed_reg;

  heat_res_t expected_q [$];
  int  fail_cnt = 0;
  int  beat_cnt = 0;
  bit  hold_req = 1'b0;
  bit  calm     = 1'b0;   // no idling on either side while set

  function automatic logic [7:0] next_rand_byte();
    logic [31:0] x;
    x = rnd_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rnd_state = x;
    return x[7:0];
  endfunction

  // One generation: seed the source rows, raise density, average upward, scan for burn-out
  function automatic void advance_generation();
    int d, base, src, nd, top, btm, c, v, col, mir, r1, r2;
    bit all_hot;
    d    = (dens_lvl < 0) ? 0 : dens_lvl;
    base = seed_col;
    src  = FW * FH;
    seed_col = (seed_col + d / 3) % FW;
    for (int a = 0; a < d / 8; a++) begin
      col = (a + base) % FW;
      mir = (col + FW / 2) % FW;
      r1  = next_rand_byte();
      r2  = next_rand_byte();
      v   = heat_mem[src + col] + 4 + (r1 & 15) + (r1 >> 3) + (r2 & 31);
      if (v > 255) v = 255;
      heat_mem[src + col] = v[7:0];
      heat_mem[src + 2 * FW + mir] = v[7:0];
    end
    nd = (dens_lvl < 0) ? dens_lvl + 10 : d + 10;
    if (nd > DENS_CAP) nd = DENS_CAP;
    dens_lvl = nd;
    for (int b = 0; b <= FH; b += 2) begin
      for (int a = 0; a < FW; a++) begin
        top = heat_mem[(b + 2) * FW + a] + heat_mem[(b + 2) * FW + (a + FW - 1) % FW]
            + heat_mem[(b + 2) * FW + (a + 1) % FW];
        btm = heat_mem[(b + 4) * FW + a];
        c = (top + btm) >> 2;
        if (c > 1) c--;
        heat_mem[b * FW + a] = c[7:0];
        heat_mem[(b + 1) * FW + a] = 8'((c + btm) >> 1);
      end
    end
    all_hot = 1'b1;
    for (int i = 0; i < FW * FH; i++) begin
      if (heat_mem[i] < ffgs_pkg::BURN_LEVEL) begin
        all_hot = 1'b0;
        break;
      end
    end
    if (all_hot) dens_lvl = -1;
  endfunction

  function automatic heat_res_t apply_item(ffgs_pkg::op_e op, int row, int col);
    heat_res_t r;
    r.level = '0;
    case (op)
      ffgs_pkg::OP_START: begin
        foreach (heat_mem[i]) heat_mem[i] = '0;
        dens_lvl  = ffgs_pkg::DENS_START;
        rnd_state = seed_reg;
      end
      ffgs_pkg::OP_STEP: advance_generation();
      ffgs_pkg::OP_READ: begin
        if (row < FROWS && col < FW) r.level = heat_mem[row * FW + col];
      end
      default: ;
    endcase
    r.dens = dens_lvl[ffgs_pkg::DENS_W-1:0];
    r.done = (dens_lvl < 0);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat, hold it while stalled, then record what it should produce
  task automatic send_beat(ffgs_pkg::op_e op, int row, int col, bit typed,
                           heat_res_t typed_res);
    heat_res_t r;
    int gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    cell_row_i  <= row[ffgs_pkg::CELL_ROW_W-1:0];
    cell_col_i  <= col[ffgs_pkg::CELL_COL_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    beat_cnt++;
    r = apply_item(op, row, col);
    expected_q.push_back(typed ? typed_res : r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the seed register; the block must be idle
  task automatic write_seed(logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    beat_cnt++;
    seed_reg = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_beat();
    int p;
    ffgs_pkg::op_e op;
    p = $urandom_range(0, 99);
    if (p < 55) op = ffgs_pkg::OP_STEP;
    else if (p < 88) op = ffgs_pkg::OP_READ;
    else if (p < 92) op = ffgs_pkg::OP_START;
    else op = ffgs_pkg::OP_NOP;
    // reads mostly land in the field, sometimes past its bottom edge
    send_beat(op, ($urandom_range(0, 9) == 0) ? $urandom_range(FROWS, 127)
                                              : $urandom_range(0, FROWS - 1),
              $urandom_range(0, 63), 1'b0, '0);
  endtask

  // Directed rows; the first reads and the no-op see the reset state
  localparam heat_row_t DIRECTED [18] = '{
    '{ffgs_pkg::OP_READ,  7'd0,   6'd0,  1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_READ,  7'd68,  6'd63, 1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_READ,  7'd127, 6'd63, 1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_READ,  7'd69,  6'd0,  1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_NOP,   7'd85,  6'd42, 1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_START, 7'd0,   6'd0,  1'b1, '{10'sd4, 1'b0, 8'd0}},
    '{ffgs_pkg::OP_STEP,  7'd0,   6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_STEP,  7'd0,   6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_STEP,  7'd0,   6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd64,  6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd66,  6'd32, 1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd63,  6'd63, 1'b0, '0},
    '{ffgs_pkg::OP_STEP,  7'd0,   6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd62,  6'd21, 1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd65,  6'd31, 1'b0, '0},
    '{ffgs_pkg::OP_NOP,   7'd0,   6'd0,  1'b0, '0},
    '{ffgs_pkg::OP_START, 7'd127, 6'd63, 1'b0, '0},
    '{ffgs_pkg::OP_READ,  7'd64,  6'd1,  1'b0, '0}
  };

  // Receiver: check each beat against the oldest expectation, then pick the next stall
  initial begin
    heat_res_t want;
    int hold_cnt;
    int gap;
    hold_cnt = 0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        beat_cnt++;
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (heat_density_o !== want.dens) begin
            $error("heat_density: expected %0d, got %0d", want.dens, heat_density_o);
            fail_cnt++;
          end
          if (burn_done_o !== want.done) begin
            $error("burn_done: expected %0d, got %0d", want.done, burn_done_o);
            fail_cnt++;
          end
          if (cell_level_o !== want.level) begin
            $error("cell_level: expected %0d, got %0d", want.level, cell_level_o);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall_i <= 1'b1;
      end else begin
        gap = pick_gap();
        out_stall_i <= (gap > 0);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (beat_cnt != seen) begin
        seen = beat_cnt;
        idle = 0;
      end else if (++idle >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    foreach (heat_mem[i]) heat_mem[i] = '0;
    dens_lvl  = ffgs_pkg::DENS_START;
    seed_col  = 0;
    seed_reg  = 32'd1;
    rnd_state = 32'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset seed
    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                DIRECTED[i].typed, DIRECTED[i].res);
    drain();

    // largest seed: random traffic, one long receiver hold-off to back up the input
    write_seed(32'hFFFF_FFFF);
    send_beat(ffgs_pkg::OP_START, 0, 0, 1'b0, '0);
    for (int i = 0; i < 40; i++) begin
      calm = (i >= 10 && i < 20);
      if (i == 20) hold_req = 1'b1;
      random_beat();
    end
    calm = 1'b0;
    drain();

    // zero seed: every draw gives 0
    write_seed(32'd0);
    send_beat(ffgs_pkg::OP_START, 0, 0, 1'b0, '0);
    for (int i = 0; i < 6; i++) send_beat(ffgs_pkg::OP_STEP, 0, 0, 1'b0, '0);
    send_beat(ffgs_pkg::OP_READ, 64, 5, 1'b0, '0);
    send_beat(ffgs_pkg::OP_READ, 66, 37, 1'b0, '0);
    drain();

    // random seed: a long burn with occasional reads, then mixed traffic
    write_seed({16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535))});
    send_beat(ffgs_pkg::OP_START, 0, 0, 1'b0, '0);
    for (int i = 0; i < 60; i++) begin
      send_beat(ffgs_pkg::OP_STEP, 0, 0, 1'b0, '0);
      if (i % 20 == 19) send_beat(ffgs_pkg::OP_READ, $urandom_range(0, FROWS - 1),
                                  $urandom_range(0, 63), 1'b0, '0);
    end
    for (int i = 0; i < 5; i++) random_beat();
    drain();

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffgs_pkg.sv
rtl/ffgs_ram.sv
rtl/ffgs_ctrl.sv
rtl/ffgs_dp.sv
rtl/fire_field_generation_step.sv
sim/fire_field_generation_step_tb.sv
